// ===== sv/lgs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants, command codes and the B3/S23 cell rule for the Life
// generation step unit.
// ----------------------------------------------------------------------------
package lgs_pkg;

  // default board size
  localparam int BOARD_WIDTH  = 64;
  localparam int BOARD_HEIGHT = 16;

  // fixed field widths of the channels
  localparam int CMD_W  = 2;
  localparam int COL_W  = 6;
  localparam int BAND_W = 1;
  localparam int BYTE_W = 8;

  // rows held by one board byte
  localparam int BAND_ROWS = 8;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2
  } lgs_cmd_t;

  // controls from the sequencer to the column window
  typedef struct packed {
    logic clear;
    logic load;
    logic advance;
  } lgs_win_ctrl_t;

  // next state of one cell from its own state and its eight neighbors
  function automatic logic life_cell(input logic alive, input logic [7:0] nbrs);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(nbrs[i]);
    end
    return (n == BIRTH_COUNT) || (alive && (n == SURVIVE_COUNT));
  endfunction

endpackage
`default_nettype wire

// ===== sv/lgs_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_if
// Valid/ready channels of the Life generation step unit: the command
// channel and the result channel.
// ----------------------------------------------------------------------------
interface lgs_cmd_if import lgs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [COL_W-1:0]  column;
  logic [BAND_W-1:0] band;
  logic [BYTE_W-1:0] data;

  modport source (output valid, output cmd, output column, output band, output data,
                  input ready);
  modport sink   (input valid, input cmd, input column, input band, input data,
                  output ready);
endinterface

interface lgs_rsp_if import lgs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink   (input valid, input read_data, output ready);
endinterface
`default_nettype wire

// ===== sv/lgs_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_window
// Three-column window of the board (west, center, east). The east column is
// filled one byte per cycle through a shift register; the new state of one
// band of the center column is worked out eight cells at a time.
// ----------------------------------------------------------------------------
module lgs_window import lgs_pkg::*; #(
  parameter  int HEIGHT = BOARD_HEIGHT,
  localparam int NBANDS = (HEIGHT + BAND_ROWS - 1) / BAND_ROWS,
  localparam int BW     = (NBANDS > 1) ? $clog2(NBANDS) : 1,
  localparam int RH     = NBANDS * BAND_ROWS
) (
  input  logic              clk,
  input  lgs_win_ctrl_t     ctrl,
  input  logic [BYTE_W-1:0] load_byte,
  input  logic [BW-1:0]     band,
  output logic [BYTE_W-1:0] band_byte
);

  // row r of a column sits at bit RH-1-r
  logic [RH-1:0]     col_w;
  logic [RH-1:0]     col_c;
  logic [RH-1:0]     col_e;
  logic [RH-1:0]     col_e_m;
  logic [RH-1:0]     row_mask;
  logic [RH+1:0]     pad_w;
  logic [RH+1:0]     pad_c;
  logic [RH+1:0]     pad_e;
  logic [BW-1:0]     band_rev;
  logic [BW+2:0]     base;
  logic [BYTE_W+1:0] win_w;
  logic [BYTE_W+1:0] win_c;
  logic [BYTE_W+1:0] win_e;
  logic [BYTE_W-1:0] fresh;

  // rows below the board are never live
  for (genvar r = 0; r < RH; r++) begin : g_mask
    assign row_mask[RH-1-r] = 1'(r < HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      col_w <= '0;
      col_c <= '0;
      col_e <= '0;
    end else if (ctrl.advance) begin
      col_w <= col_c;
      col_c <= col_e_m;
      col_e <= '0;
    end else if (ctrl.load) begin
      // bands arrive top first and end up in the high bits
      col_e <= RH'({col_e, load_byte});
    end
  end

  always_comb begin
    col_e_m  = col_e & row_mask;
    pad_w    = {1'b0, col_w, 1'b0};
    pad_c    = {1'b0, col_c, 1'b0};
    pad_e    = {1'b0, col_e_m, 1'b0};
    band_rev = BW'(NBANDS - 1) - band;
    base     = {band_rev, 3'b000};
    // band rows plus one row above and one below
    win_w    = pad_w[base +: BYTE_W+2];
    win_c    = pad_c[base +: BYTE_W+2];
    win_e    = pad_e[base +: BYTE_W+2];
    for (int i = 0; i < BYTE_W; i++) begin
      fresh[i] = life_cell(win_c[i+1], {win_w[i], win_w[i+1], win_w[i+2],
                                        win_c[i], win_c[i+2],
                                        win_e[i], win_e[i+1], win_e[i+2]});
    end
    band_byte = fresh & row_mask[base +: BYTE_W];
  end

endmodule
`default_nettype wire

// ===== sv/life_generation_step_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// life_generation_step_unit
// Life board (B3/S23, dead border) in a byte memory with write, read and
// advance-one-generation commands.
// ----------------------------------------------------------------------------
// req carries cmd, column, band and data; rsp returns one read_data byte per
// command: the addressed byte after the command, or zero for an address off
// the board. Commands are taken one at a time; req.ready is high only while
// the unit is idle.
// Write and read pass through S_RD and then S_FIN, where the result is loaded
// into the output register before the unit returns to idle.
// A generation walks the board column by column through a three-column
// window. The single read and single write port of the board memory set the
// pace: per column NB byte reads (S_LOAD) plus NB byte writes (S_CMP), with
// NB = ceil(HEIGHT/8), and the S_GAP and S_SHIFT steps between them.
// After reset a clearing pass writes zero to all 2**(BW+CW) memory words
// (128 at the defaults) before the first command is taken.
// A stalled rsp holds its byte; the unit finishes its current command and
// then waits to load the result until the output register is free, while
// an earlier result may still be waiting.
// ----------------------------------------------------------------------------
module life_generation_step_unit import lgs_pkg::*; #(
  parameter  int WIDTH  = BOARD_WIDTH,
  parameter  int HEIGHT = BOARD_HEIGHT,
  localparam int NBANDS = (HEIGHT + BAND_ROWS - 1) / BAND_ROWS,
  localparam int BW     = (NBANDS > 1) ? $clog2(NBANDS) : 1,
  localparam int CW     = $clog2(WIDTH),
  localparam int AW     = BW + CW,
  localparam int DEPTH  = 2 ** AW
) (
  input  logic      clk,
  input  logic      rst,
  lgs_cmd_if.sink   req,
  lgs_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_GAP, S_CMP, S_SHIFT, S_RD, S_FIN
  } state_t;

  state_t            state;
  logic [AW-1:0]     clr_addr;
  logic [CW-1:0]     gx;
  logic [BW-1:0]     gb;
  logic              first;
  logic              ld_pend;
  logic [AW-1:0]     lat_addr;
  logic              lat_ok;
  logic              out_valid;
  logic [BYTE_W-1:0] out_data;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;

  lgs_cmd_t          req_cmd;
  logic              req_fire;
  logic              req_ok;
  logic [AW-1:0]     req_addr;
  logic [CW-1:0]     load_col;
  lgs_win_ctrl_t     win_ctrl;
  logic [BYTE_W-1:0] band_byte;

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;

  always_comb begin
    req_cmd  = lgs_cmd_t'(req.cmd);
    req_fire = req.valid && req.ready;
    req_ok   = (32'(req.column) < WIDTH) && (32'(req.band) < NBANDS);
    req_addr = {BW'(req.band), CW'(req.column)};
    // column to fetch next: column 0 on the first pass, else one ahead
    load_col = first ? '0 : gx + 1'b1;

    win_ctrl.clear   = req_fire && (req_cmd == CMD_STEP);
    win_ctrl.load    = ld_pend;
    win_ctrl.advance = (state == S_SHIFT);

    mem_we    = 1'b0;
    mem_waddr = {gb, gx};
    mem_wdata = band_byte;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_IDLE: begin
        mem_we    = req_fire && (req_cmd == CMD_WRITE) && req_ok;
        mem_waddr = req_addr;
        mem_wdata = req.data;
      end
      S_CMP: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
    mem_raddr = (state == S_LOAD) ? {gb, load_col} : lat_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  lgs_window #(
    .HEIGHT (HEIGHT)
  ) u_window (
    .clk       (clk),
    .ctrl      (win_ctrl),
    .load_byte (rd_data),
    .band      (gb),
    .band_byte (band_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      gx        <= '0;
      gb        <= '0;
      first     <= 1'b0;
      ld_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // read data lands in the cycle after the fetch
      ld_pend <= (state == S_LOAD);
      if (out_valid && rsp.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            lat_addr <= req_addr;
            lat_ok   <= req_ok;
            if (req_cmd == CMD_STEP) begin
              first <= 1'b1;
              gx    <= '0;
              gb    <= '0;
              state <= S_LOAD;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_LOAD: begin
          if (gb == BW'(NBANDS - 1)) begin
            gb    <= '0;
            state <= S_GAP;
          end else begin
            gb <= gb + 1'b1;
          end
        end
        S_GAP: begin
          state <= first ? S_SHIFT : S_CMP;
        end
        S_CMP: begin
          if (gb == BW'(NBANDS - 1)) begin
            gb    <= '0;
            state <= S_SHIFT;
          end else begin
            gb <= gb + 1'b1;
          end
        end
        S_SHIFT: begin
          if (!first && (gx == CW'(WIDTH - 1))) begin
            state <= S_RD;
          end else begin
            first <= 1'b0;
            gx    <= load_col;
            // last column has only dead cells to its east
            state <= (load_col == CW'(WIDTH - 1)) ? S_CMP : S_LOAD;
          end
        end
        S_RD: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_data  <= lat_ok ? rd_data : '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/lgs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks of the Life generation step unit, bound to the top level.
// ----------------------------------------------------------------------------
module lgs_checker import lgs_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_ready,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire logic [BYTE_W-1:0] rsp_read_data
);

  // reset starts the clearing pass with no result pending
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("unit not quiet after reset");

  // one command in flight at a time
  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second command taken while busy");

  // a result never appears in the cycle right after a transfer
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(rsp_valid))
    else $error("result too early");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
    else $error("stalled result changed");

endmodule

bind life_generation_step_unit lgs_checker u_lgs_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_read_data (rsp.read_data)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Life generation step unit.
// Drives write, read, advance and spare commands with random gaps and checks each
// returned byte against a board model in the bench or a typed row's fixed value.
// Short directed table first, then randomized episodes of patterns and generations.
// ----------------------------------------------------------------------------
module tb import lgs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BOARD_BANDS = (BOARD_HEIGHT + BAND_ROWS - 1) / BAND_ROWS;
  localparam int BOARD_BYTES = BOARD_WIDTH * BOARD_BANDS;
  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_LIMIT = 4000;
  localparam int RSP_HOLDOFF = 600;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [COL_W-1:0]  column;
    logic [BAND_W-1:0] band;
    logic [BYTE_W-1:0] data;
    logic              typed;
    logic [BYTE_W-1:0] want;
  } plan_row_t;

  localparam int PLAN_ROWS = 25;

  plan_row_t directed_plan [0:PLAN_ROWS-1] = '{
    '{CMD_READ,  6'd0,  1'b0, 8'h00, 1'b1, 8'h00},
    '{CMD_READ,  6'd63, 1'b1, 8'hFF, 1'b1, 8'h00},
    '{CMD_WRITE, 6'd0,  1'b0, 8'hFF, 1'b1, 8'hFF},
    '{CMD_WRITE, 6'd63, 1'b1, 8'h80, 1'b1, 8'h80},
    // spare command leaves the board alone
    '{CMD_SPARE, 6'd0,  1'b0, 8'h55, 1'b1, 8'hFF},
    '{CMD_READ,  6'd63, 1'b1, 8'hAA, 1'b1, 8'h80},
    // line of eight against the left edge
    '{CMD_STEP,  6'd0,  1'b1, 8'h00, 1'b0, 8'h00},
    '{CMD_READ,  6'd1,  1'b0, 8'h00, 1'b0, 8'h00},
    '{CMD_READ,  6'd0,  1'b0, 8'h00, 1'b0, 8'h00},
    // vertical blinker across the band boundary
    '{CMD_WRITE, 6'd20, 1'b0, 8'h01, 1'b1, 8'h01},
    '{CMD_WRITE, 6'd20, 1'b1, 8'hC0, 1'b1, 8'hC0},
    '{CMD_STEP,  6'd20, 1'b0, 8'h00, 1'b0, 8'h00},
    '{CMD_READ,  6'd19, 1'b0, 8'h00, 1'b0, 8'h00},
    '{CMD_READ,  6'd21, 1'b1, 8'h00, 1'b0, 8'h00},
    // full 3x3 square, center dies of overcrowding
    '{CMD_WRITE, 6'd40, 1'b0, 8'hE0, 1'b1, 8'hE0},
    '{CMD_WRITE, 6'd41, 1'b0, 8'hE0, 1'b1, 8'hE0},
    '{CMD_WRITE, 6'd42, 1'b0, 8'hE0, 1'b1, 8'hE0},
    '{CMD_STEP,  6'd41, 1'b0, 8'h00, 1'b0, 8'h00},
    // block in the bottom-right corner must not wrap
    '{CMD_WRITE, 6'd62, 1'b1, 8'h03, 1'b1, 8'h03},
    '{CMD_WRITE, 6'd63, 1'b1, 8'h03, 1'b1, 8'h03},
    '{CMD_STEP,  6'd63, 1'b1, 8'h00, 1'b0, 8'h00},
    '{CMD_READ,  6'd62, 1'b1, 8'h00, 1'b0, 8'h00},
    '{CMD_WRITE, 6'd31, 1'b1, 8'hAA, 1'b1, 8'hAA},
    '{CMD_WRITE, 6'd31, 1'b1, 8'h55, 1'b1, 8'h55},
    '{CMD_STEP,  6'd31, 1'b1, 8'h00, 1'b0, 8'h00}
  };

  logic clk;
  logic rst;

  lgs_cmd_if cmd_ch ();
  lgs_rsp_if rsp_ch ();

  life_generation_step_unit uut (
    .clk (clk),
    .rst (rst),
    .req (cmd_ch),
    .rsp (rsp_ch)
  );

  logic [BYTE_W-1:0] life_board  [0:BOARD_BYTES-1];
  logic [BYTE_W-1:0] prior_board [0:BOARD_BYTES-1];
  logic [BYTE_W-1:0] expected_bytes [$];
  int mismatches     = 0;
  int bytes_received = 0;
  int items_sent     = 0;
  int quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    cmd_ch.valid  = 1'b0;
    cmd_ch.cmd    = '0;
    cmd_ch.column = '0;
    cmd_ch.band   = '0;
    cmd_ch.data   = '0;
    rsp_ch.ready  = 1'b0;
    for (int i = 0; i < BOARD_BYTES; i++) begin
      life_board[i]  = '0;
      prior_board[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------- board model ----------------

  function automatic logic prior_cell(input int x, input int y);
    if (x < 0 || y < 0 || x >= BOARD_WIDTH || y >= BOARD_HEIGHT) begin
      return 1'b0;
    end
    return prior_board[x + (y / BAND_ROWS) * BOARD_WIDTH][BAND_ROWS - 1 - (y % BAND_ROWS)];
  endfunction

  function automatic void advance_board();
    logic [3:0] n;
    logic alive;
    prior_board = life_board;
    // rows below the board in the last band are cleared by a generation
    for (int i = 0; i < BOARD_BYTES; i++) begin
      life_board[i] = '0;
    end
    for (int x = 0; x < BOARD_WIDTH; x++) begin
      for (int y = 0; y < BOARD_HEIGHT; y++) begin
        n = '0;
        for (int dx = -1; dx <= 1; dx++) begin
          for (int dy = -1; dy <= 1; dy++) begin
            if (dx != 0 || dy != 0) begin
              n = n + 4'(prior_cell(x + dx, y + dy));
            end
          end
        end
        alive = prior_cell(x, y);
        life_board[x + (y / BAND_ROWS) * BOARD_WIDTH][BAND_ROWS - 1 - (y % BAND_ROWS)] =
          (n == BIRTH_COUNT) || (alive && n == SURVIVE_COUNT);
      end
    end
  endfunction

  function automatic logic [BYTE_W-1:0] apply_command(input logic [CMD_W-1:0] c,
                                                      input logic [COL_W-1:0] col,
                                                      input logic [BAND_W-1:0] b,
                                                      input logic [BYTE_W-1:0] d);
    bit on_board;
    int idx;
    on_board = (int'(col) < BOARD_WIDTH) && (int'(b) < BOARD_BANDS);
    idx = int'(col) + int'(b) * BOARD_WIDTH;
    if (c == CMD_WRITE) begin
      if (on_board) life_board[idx] = d;
    end else if (c == CMD_STEP) begin
      advance_board();
    end
    return on_board ? life_board[idx] : '0;
  endfunction

  // ---------------- stimulus ----------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return BYTE_W'($urandom() & $urandom() & $urandom());
      1: return BYTE_W'($urandom() & $urandom());
      2: return BYTE_W'($urandom());
      3: return BYTE_W'($urandom() | $urandom());
      4: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [COL_W-1:0] near_col(input int base);
    return COL_W'(base + int'($urandom_range(0, 4)) - 2);
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] c, input logic [COL_W-1:0] col,
                           input logic [BAND_W-1:0] b, input logic [BYTE_W-1:0] d,
                           input logic typed, input logic [BYTE_W-1:0] want, input int gap);
    logic [BYTE_W-1:0] predicted;
    cmd_ch.valid  <= 1'b1;
    cmd_ch.cmd    <= c;
    cmd_ch.column <= col;
    cmd_ch.band   <= b;
    cmd_ch.data   <= d;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predicted = apply_command(c, col, b, d);
    expected_bytes.push_back(typed ? want : predicted);
    items_sent++;
    // valid stays up for a back-to-back transfer
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input logic [CMD_W-1:0] c, input logic [COL_W-1:0] col);
    send_item(c, col, BAND_W'($urandom_range(0, 1)), BYTE_W'($urandom()), 1'b0, '0,
              pick_gap());
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    wait (expected_bytes.size() == 0);
    @(posedge clk);
  endtask

  initial begin
    int base;
    bit mid_drain_done;
    mid_drain_done = 0;
    do @(posedge clk); while (rst);

    foreach (directed_plan[i]) begin
      send_item(directed_plan[i].cmd, directed_plan[i].column, directed_plan[i].band,
                directed_plan[i].data, directed_plan[i].typed, directed_plan[i].want,
                pick_gap());
    end
    drain_results();

    while (items_sent < PLAN_ROWS + RANDOM_ITEMS) begin
      if (!mid_drain_done && items_sent >= PLAN_ROWS + RANDOM_ITEMS / 2) begin
        mid_drain_done = 1;
        drain_results();
      end
      base = $urandom_range(0, BOARD_WIDTH - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // seed a patch, then run it a few generations and look around
          repeat ($urandom_range(1, 12)) begin
            send_item(CMD_WRITE, near_col(base), BAND_W'($urandom_range(0, 1)), pick_byte(),
                      1'b0, '0, pick_gap());
          end
          repeat ($urandom_range(1, 4)) begin
            send_random(CMD_STEP, near_col(base));
            repeat ($urandom_range(0, 3)) send_random(CMD_READ, near_col(base));
          end
        end
        6, 7: begin
          repeat ($urandom_range(1, 10)) begin
            send_random(CMD_W'($urandom_range(0, 3)), COL_W'($urandom()));
          end
        end
        8: begin
          repeat ($urandom_range(2, 8)) send_random(CMD_READ, COL_W'($urandom()));
        end
        default: begin
          // wipe a stretch of columns so the board does not stay cluttered
          for (int k = 0; k < 8; k++) begin
            send_item(CMD_WRITE, COL_W'(base + k), 1'b0, '0, 1'b0, '0, pick_gap());
            send_item(CMD_WRITE, COL_W'(base + k), 1'b1, '0, 1'b0, '0, pick_gap());
          end
          send_random(CMD_SPARE, COL_W'(base));
        end
      endcase
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // ---------------- result side ----------------

  task automatic hold_ready(input logic level, input int cycles);
    repeat (cycles) begin
      rsp_ch.ready <= level;
      @(posedge clk);
    end
  endtask

  initial begin
    bit long_stall_done;
    long_stall_done = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (!long_stall_done && bytes_received >= 300) begin
        // long hold-off so the unit backs up and stalls the command side
        long_stall_done = 1;
        hold_ready(1'b0, RSP_HOLDOFF);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: hold_ready(1'b1, $urandom_range(1, 20));
          4, 5, 6, 7: hold_ready(1'b0, $urandom_range(1, 3));
          8:          hold_ready(1'b0, $urandom_range(5, 30));
          default:    hold_ready(1'b1, $urandom_range(50, 200));
        endcase
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                 input logic [BYTE_W-1:0] want);
    $display("[%0t] mismatch: %s: read_data %02h, expected %02h", $realtime, what, got, want);
    mismatches++;
  endtask

  logic [BYTE_W-1:0] oldest_byte;

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      bytes_received++;
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected transfer", rsp_ch.read_data, '0);
      end else begin
        oldest_byte = expected_bytes.pop_front();
        if (rsp_ch.read_data !== oldest_byte) begin
          report_mismatch("wrong byte", rsp_ch.read_data, oldest_byte);
        end
      end
    end
  end

  // no transfer on either side for too long means the unit is stuck
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
